@@ design/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled while reset is asserted.
`define AST_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Expression that must never hold while out of reset.
`define AST_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("assertion failed");

`endif

@@ design/cwc_pkg.sv @@
// Package: types and constants of the collapse cell.
package cwc_pkg;

    localparam int NUM_PATTERNS_DEF = 16;
    localparam int MAX_PATTERNS     = 16;
    localparam int LOG_ITERS        = 24;
    localparam int NUM_W            = 49;
    localparam int SUM_W            = 20;
    localparam int ENT_W            = 14;
    localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;
    localparam logic [13:0] ENT_MAX = 14'h3FFF;

    localparam logic [1:0] CMD_LOAD      = 2'd0;
    localparam logic [1:0] CMD_CONSTRAIN = 2'd1;
    localparam logic [1:0] CMD_COLLAPSE  = 2'd2;

    localparam logic KIND_SUMMARY  = 1'b0;
    localparam logic KIND_COLLAPSE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DROP,
        ST_SUM,
        ST_ENT_W,
        ST_LOG_START,
        ST_LOG_IT,
        ST_LOG_MUL,
        ST_CMP,
        ST_DIV,
        ST_LN_MUL,
        ST_SCALE,
        ST_WALK,
        ST_OUT
    } state_t;

endpackage

@@ design/wfc_cell_weight_collapse.sv @@
// Collapse cell: per-pattern weights, run summaries with entropy, roulette collapse.
// A run end sums the weights and takes the entropy with the 24-step log loop and the
// 49-step divider; the log loop, the ln2 scaling and the collapse scaling share one
// 32x32 multiplier. A collapse sums the weights and walks them to the chosen pattern.
// One word is in flight at a time.
// Reset (aresetn low, synchronous) clears all weights and the collapse state.
module wfc_cell_weight_collapse
    import cwc_pkg::*;
#(
    parameter int NUM_PATTERNS = NUM_PATTERNS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // pattern_id[4:0], weight[20:5], random_value[36:21]
    input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // changed[0], weight_sum[20:1], entropy[34:21],
                                       // possible_mask[50:35], chosen_pattern[55:51],
                                       // contradiction[56]
    output logic [0:0]  m_axis_tuser   // kind[0]
);

    localparam int IW = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
    localparam logic [IW-1:0] IDX_LAST = IW'(NUM_PATTERNS - 1);

    state_t state_reg, state_next;

    logic [15:0]         weights_reg [NUM_PATTERNS];
    logic [15:0]         weights_next [NUM_PATTERNS];
    logic [NUM_PATTERNS-1:0] named_reg, named_next;
    logic                run_changed_reg, run_changed_next;
    logic                collapsed_reg, collapsed_next;
    logic [4:0]          final_reg, final_next;
    logic                m_valid_reg, m_valid_next;

    logic [IW-1:0]       idx_reg, idx_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic                is_col_reg, is_col_next;
    logic                from_con_reg, from_con_next;
    logic [15:0]         rnd_reg, rnd_next;
    logic [SUM_W-1:0]    x_reg, x_next;
    logic [30:0]         m_reg, m_next;
    logic [4:0]          n_reg, n_next;
    logic [LOG_ITERS-1:0] frac_reg, frac_next;
    logic [4:0]          it_reg, it_next;
    logic                log_sum_reg, log_sum_next;
    logic [NUM_W-1:0]    acc_reg, acc_next;
    logic [NUM_W-1:0]    top_reg, top_next;
    logic [NUM_W-1:0]    quo_reg, quo_next;
    logic [SUM_W-1:0]    rem_reg, rem_next;
    logic [5:0]          div_cnt_reg, div_cnt_next;
    logic [ENT_W-1:0]    ent_reg, ent_next;
    logic [4:0]          chosen_reg, chosen_next;
    logic                contr_reg, contr_next;
    logic [SUM_W-1:0]    r_reg, r_next;
    logic [63:0]         m_data_reg, m_data_next;
    logic                m_user_reg, m_user_next;

    logic [4:0]          in_pid;
    logic [15:0]         in_weight;
    logic [15:0]         in_rnd;
    logic [1:0]          in_cmd;
    logic                accept;
    logic                pid_ok;
    logic [4:0]          pid_m1;
    logic [IW-1:0]       rd_idx;
    logic [15:0]         rd_w;
    logic                idx_last;
    logic [SUM_W-1:0]    sum_add;
    logic                sum_dead;
    logic [4:0]          msb_pos;
    logic [49:0]         norm_sh;
    logic [31:0]         mul_a, mul_b;
    logic [63:0]         mul_p;
    logic [31:0]         sq;
    logic [SUM_W:0]      rem_sh;
    logic                rem_ge;
    logic [63:0]         ln_rnd;
    logic [15:0]         mask;
    logic                out_free;

    assign in_pid    = s_axis_tdata[4:0];
    assign in_weight = s_axis_tdata[20:5];
    assign in_rnd    = s_axis_tdata[36:21];
    assign in_cmd    = s_axis_tuser;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pid_ok        = (in_pid >= 5'd1) && (in_pid <= 5'(NUM_PATTERNS));
    assign pid_m1        = in_pid - 5'd1;
    assign rd_idx        = (state_reg == ST_IDLE) ? pid_m1[IW-1:0] : idx_reg;
    assign rd_w          = weights_reg[rd_idx];
    assign idx_last      = (idx_reg == IDX_LAST);
    assign sum_add       = sum_reg + {4'd0, rd_w};
    assign sum_dead      = collapsed_reg || (sum_add == '0);
    assign out_free      = !m_valid_reg || m_axis_tready;

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_LOG_IT: begin
                mul_a = {1'b0, m_reg};
                mul_b = {1'b0, m_reg};
            end
            ST_LOG_MUL: begin
                mul_a = {12'd0, x_reg};
                mul_b = {3'd0, n_reg, frac_reg};
            end
            ST_LN_MUL: begin
                mul_a = quo_reg[31:0];
                mul_b = LN2_Q32;
            end
            ST_SCALE: begin
                mul_a = {16'd0, rnd_reg};
                mul_b = {12'd0, sum_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    always_comb begin
        msb_pos = '0;
        for (int i = 0; i < SUM_W; i++) begin
            if (x_reg[i]) begin
                msb_pos = 5'(i);
            end
        end
    end
    assign norm_sh = {x_reg, 30'd0} >> msb_pos;
    assign sq      = mul_p[61:30];
    assign rem_sh  = {rem_reg, quo_reg[NUM_W-1]};
    assign rem_ge  = (rem_sh >= {1'b0, sum_reg});
    assign ln_rnd  = mul_p + 64'h0000_0800_0000_0000;

    always_comb begin
        mask = '0;
        if (collapsed_reg) begin
            mask = 16'd1 << (final_reg - 5'd1);
        end else begin
            for (int i = 0; i < NUM_PATTERNS; i++) begin
                mask[i] = (weights_reg[i] != '0);
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if ((in_cmd == CMD_LOAD || in_cmd == CMD_CONSTRAIN) && s_axis_tlast) begin
                        state_next = ST_DROP;
                    end else if (in_cmd == CMD_COLLAPSE) begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_DROP:      state_next = ST_SUM;
            ST_SUM: begin
                if (idx_last) begin
                    if (sum_dead) state_next = ST_OUT;
                    else if (is_col_reg) state_next = ST_SCALE;
                    else state_next = ST_ENT_W;
                end
            end
            ST_ENT_W: begin
                if (rd_w != '0 || idx_last) state_next = ST_LOG_START;
            end
            ST_LOG_START: state_next = ST_LOG_IT;
            ST_LOG_IT: begin
                if (it_reg == 5'(LOG_ITERS - 1)) state_next = ST_LOG_MUL;
            end
            ST_LOG_MUL: begin
                if (log_sum_reg) state_next = ST_CMP;
                else if (idx_last) state_next = ST_LOG_START;
                else state_next = ST_ENT_W;
            end
            ST_CMP: begin
                state_next = (acc_reg >= top_reg) ? ST_OUT : ST_DIV;
            end
            ST_DIV: begin
                if (div_cnt_reg == 6'(NUM_W - 1)) state_next = ST_LN_MUL;
            end
            ST_LN_MUL:    state_next = ST_OUT;
            ST_SCALE:     state_next = ST_WALK;
            ST_WALK: begin
                if (r_reg < {4'd0, rd_w} || idx_last) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        weights_next     = weights_reg;
        named_next       = named_reg;
        run_changed_next = run_changed_reg;
        collapsed_next   = collapsed_reg;
        final_next       = final_reg;
        m_valid_next     = m_valid_reg && !m_axis_tready;
        idx_next         = idx_reg;
        sum_next         = sum_reg;
        is_col_next      = is_col_reg;
        from_con_next    = from_con_reg;
        rnd_next         = rnd_reg;
        x_next           = x_reg;
        m_next           = m_reg;
        n_next           = n_reg;
        frac_next        = frac_reg;
        it_next          = it_reg;
        log_sum_next     = log_sum_reg;
        acc_next         = acc_reg;
        top_next         = top_reg;
        quo_next         = quo_reg;
        rem_next         = rem_reg;
        div_cnt_next     = div_cnt_reg;
        ent_next         = ent_reg;
        chosen_next      = chosen_reg;
        contr_next       = contr_reg;
        r_next           = r_reg;
        m_data_next      = m_data_reg;
        m_user_next      = m_user_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    rnd_next      = in_rnd;
                    is_col_next   = (in_cmd == CMD_COLLAPSE);
                    from_con_next = (in_cmd == CMD_CONSTRAIN);
                    ent_next      = '0;
                    chosen_next   = '0;
                    contr_next    = 1'b0;
                    sum_next      = '0;
                    idx_next      = '0;
                    case (in_cmd)
                        CMD_LOAD: begin
                            collapsed_next = 1'b0;
                            final_next     = '0;
                            if (pid_ok) begin
                                weights_next[pid_m1[IW-1:0]] = in_weight;
                                named_next[pid_m1[IW-1:0]]   = 1'b1;
                            end
                        end
                        CMD_CONSTRAIN: begin
                            if (!collapsed_reg && pid_ok) begin
                                named_next[pid_m1[IW-1:0]] = 1'b1;
                                if (in_weight < rd_w) begin
                                    weights_next[pid_m1[IW-1:0]] = in_weight;
                                    run_changed_next             = 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DROP: begin
                if (!collapsed_reg) begin
                    for (int i = 0; i < NUM_PATTERNS; i++) begin
                        if (!named_reg[i] && weights_reg[i] != '0) begin
                            weights_next[i] = '0;
                            if (from_con_reg) run_changed_next = 1'b1;
                        end
                    end
                end
            end
            ST_SUM: begin
                sum_next = sum_add;
                idx_next = idx_reg + 1'b1;
                if (idx_last) begin
                    idx_next = '0;
                    acc_next = '0;
                    if (sum_dead && is_col_reg) contr_next = 1'b1;
                end
            end
            ST_ENT_W: begin
                if (rd_w != '0) begin
                    x_next       = {4'd0, rd_w};
                    log_sum_next = 1'b0;
                end else if (idx_last) begin
                    x_next       = sum_reg;
                    log_sum_next = 1'b1;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_LOG_START: begin
                m_next    = norm_sh[30:0];
                n_next    = msb_pos;
                frac_next = '0;
                it_next   = '0;
            end
            ST_LOG_IT: begin
                it_next = it_reg + 5'd1;
                if (sq[31]) begin
                    m_next    = sq[31:1];
                    frac_next = {frac_reg[LOG_ITERS-2:0], 1'b1};
                end else begin
                    m_next    = sq[30:0];
                    frac_next = {frac_reg[LOG_ITERS-2:0], 1'b0};
                end
            end
            ST_LOG_MUL: begin
                if (log_sum_reg) begin
                    top_next = mul_p[NUM_W-1:0];
                end else begin
                    acc_next = acc_reg + mul_p[NUM_W-1:0];
                    if (idx_last) begin
                        x_next       = sum_reg;
                        log_sum_next = 1'b1;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_CMP: begin
                quo_next     = top_reg - acc_reg;
                rem_next     = '0;
                div_cnt_next = '0;
            end
            ST_DIV: begin
                div_cnt_next = div_cnt_reg + 6'd1;
                rem_next     = rem_ge ? SUM_W'(rem_sh - {1'b0, sum_reg}) : rem_sh[SUM_W-1:0];
                quo_next     = {quo_reg[NUM_W-2:0], rem_ge};
            end
            ST_LN_MUL: begin
                ent_next = (ln_rnd[63:44] > {6'd0, ENT_MAX}) ? ENT_MAX : ln_rnd[57:44];
            end
            ST_SCALE: begin
                r_next   = mul_p[35:16];
                idx_next = '0;
            end
            ST_WALK: begin
                if (r_reg < {4'd0, rd_w}) begin
                    chosen_next    = 5'(idx_reg) + 5'd1;
                    final_next     = 5'(idx_reg) + 5'd1;
                    collapsed_next = 1'b1;
                end else begin
                    r_next   = r_reg - {4'd0, rd_w};
                    idx_next = idx_reg + 1'b1;
                    if (idx_last) contr_next = 1'b1;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_user_next  = is_col_reg ? KIND_COLLAPSE : KIND_SUMMARY;
                    m_data_next  = {7'd0, contr_reg, chosen_reg, mask, ent_reg, sum_reg,
                                    (!is_col_reg && run_changed_reg)};
                    if (!is_col_reg) begin
                        named_next       = '0;
                        run_changed_next = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            named_reg       <= '0;
            run_changed_reg <= 1'b0;
            collapsed_reg   <= 1'b0;
            final_reg       <= '0;
            m_valid_reg     <= 1'b0;
            for (int i = 0; i < NUM_PATTERNS; i++) weights_reg[i] <= '0;
        end else begin
            state_reg       <= state_next;
            named_reg       <= named_next;
            run_changed_reg <= run_changed_next;
            collapsed_reg   <= collapsed_next;
            final_reg       <= final_next;
            m_valid_reg     <= m_valid_next;
            weights_reg     <= weights_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        sum_reg     <= sum_next;
        is_col_reg  <= is_col_next;
        from_con_reg <= from_con_next;
        rnd_reg     <= rnd_next;
        x_reg       <= x_next;
        m_reg       <= m_next;
        n_reg       <= n_next;
        frac_reg    <= frac_next;
        it_reg      <= it_next;
        log_sum_reg <= log_sum_next;
        acc_reg     <= acc_next;
        top_reg     <= top_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        div_cnt_reg <= div_cnt_next;
        ent_reg     <= ent_next;
        chosen_reg  <= chosen_next;
        contr_reg   <= contr_next;
        r_reg       <= r_next;
        m_data_reg  <= m_data_next;
        m_user_reg  <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

@@ design/cwc_checker.sv @@
// Port-level checker for the collapse cell, bound to the top level.
`include "assert_macros.svh"

module cwc_checker
    import cwc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [39:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    `AST_CLK(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    `AST_NEVER(a_summary_clean, aclk, aresetn, m_axis_tvalid && m_axis_tuser[0] == KIND_SUMMARY && (m_axis_tdata[56] || m_axis_tdata[55:51] != 5'd0))
    `AST_CLK(a_pick_onehot, aclk, aresetn, m_axis_tvalid && m_axis_tuser[0] == KIND_COLLAPSE && !m_axis_tdata[56] |-> m_axis_tdata[55:51] != 5'd0 && m_axis_tdata[34:21] == 14'd0 && $onehot(m_axis_tdata[50:35]))
    `AST_NEVER(a_contra_nopick, aclk, aresetn, m_axis_tvalid && m_axis_tdata[56] && m_axis_tdata[55:51] != 5'd0)

endmodule

bind wfc_cell_weight_collapse cwc_checker u_cwc_checker (.*);

@@ sim/wfc_cell_weight_collapse_tb.sv @@
// Testbench of the collapse cell: random load, constrain and collapse traffic vs a predictor.
module wfc_cell_weight_collapse_tb;
    import cwc_pkg::*;

    typedef struct {
        logic [1:0]  cmd;
        logic [4:0]  pid;
        logic [15:0] weight;
        logic        last;
        logic [15:0] rnd;
        bit          drain;
    } cell_word_t;

    typedef struct {
        logic        kind;
        logic        changed;
        logic [19:0] wsum;
        logic [13:0] ent;
        logic [15:0] mask;
        logic [4:0]  chosen;
        logic        contra;
    } cell_answer_t;

    localparam logic [1:0] CMD_NOP = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    wfc_cell_weight_collapse DUT (.*);

    always #5 aclk = ~aclk;

    cell_word_t   pending_words[$];
    cell_answer_t expected_answers[$];
    cell_word_t   cur_word;
    int  rst_cnt = 0;
    int  burst_left = 5, gap_left = 0;
    int  stall_hold = 0, ready_mode = 0, mode_cnt = 0, answers_seen = 0;
    bit  long_hold_done = 0;
    int  mismatches = 0;

    // cell state mirror
    logic [15:0] w_mirror[16];
    logic [15:0] named_mask;
    logic        run_chg, collapsed;
    logic [4:0]  final_pat;

    always @(posedge aclk) begin
        if (rst_cnt < 4) rst_cnt <= rst_cnt + 1;
        aresetn <= (rst_cnt >= 3);
    end

    function automatic logic [63:0] log2_fix(input logic [31:0] x);
        int n;
        logic [63:0] m, frac;
        n = 0;
        frac = 0;
        while (n < 31 && (x >> (n + 1)) != 0) n++;
        m = ({32'd0, x} << 30) >> n;
        for (int i = 0; i < 24; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return (64'(n) << 24) | frac;
    endfunction

    function automatic logic [19:0] weight_sum_now();
        logic [19:0] s;
        s = 0;
        for (int i = 0; i < 16; i++) s += w_mirror[i];
        return s;
    endfunction

    function automatic logic [13:0] entropy_now(input logic [19:0] s);
        logic [63:0] acc, top, h2, p;
        acc = 0;
        if (collapsed || s == 0) return 0;
        for (int i = 0; i < 16; i++)
            if (w_mirror[i] != 0) acc += 64'(w_mirror[i]) * log2_fix(32'(w_mirror[i]));
        top = 64'(s) * log2_fix(32'(s));
        if (acc >= top) return 0;
        h2 = (top - acc) / 64'(s);
        p = (h2 * 64'(LN2_Q32) + (64'd1 << 43)) >> 44;
        return (p > 16383) ? ENT_MAX : p[13:0];
    endfunction

    function automatic logic [15:0] mask_now();
        logic [15:0] m;
        m = 0;
        if (collapsed) begin
            if (final_pat >= 1 && final_pat <= 16) m[final_pat - 1] = 1'b1;
            return m;
        end
        for (int i = 0; i < 16; i++) m[i] = (w_mirror[i] != 0);
        return m;
    endfunction

    task automatic predict_cell(input cell_word_t w);
        cell_answer_t a;
        logic [19:0] s, r;
        int pick;
        bit ok;
        ok = (w.pid >= 1 && w.pid <= 16);
        a = '{default: '0};
        if (w.cmd == CMD_NOP) return;
        if (w.cmd == CMD_COLLAPSE) begin
            s = weight_sum_now();
            a.kind = KIND_COLLAPSE;
            a.wsum = s;
            pick = 0;
            if (!collapsed && s != 0) begin
                r = 20'((64'(w.rnd) * 64'(s)) >> 16);
                for (int i = 0; i < 16; i++) begin
                    if (r < w_mirror[i]) begin
                        pick = i + 1;
                        break;
                    end
                    r -= w_mirror[i];
                end
            end
            if (pick == 0) begin
                a.ent = entropy_now(s);
                a.mask = mask_now();
                a.contra = 1'b1;
            end else begin
                collapsed = 1'b1;
                final_pat = 5'(pick);
                a.mask = mask_now();
                a.chosen = 5'(pick);
            end
            expected_answers = {expected_answers, a};
            return;
        end
        if (w.cmd == CMD_LOAD) begin
            collapsed = 1'b0;
            final_pat = 0;
            if (ok) begin
                w_mirror[w.pid - 1] = w.weight;
                named_mask[w.pid - 1] = 1'b1;
            end
        end else if (!collapsed && ok) begin
            named_mask[w.pid - 1] = 1'b1;
            if (w.weight < w_mirror[w.pid - 1]) begin
                w_mirror[w.pid - 1] = w.weight;
                run_chg = 1'b1;
            end
        end
        if (!w.last) return;
        if (!collapsed)
            for (int i = 0; i < 16; i++)
                if (!named_mask[i] && w_mirror[i] != 0) begin
                    w_mirror[i] = 0;
                    if (w.cmd == CMD_CONSTRAIN) run_chg = 1'b1;
                end
        s = weight_sum_now();
        a.kind = KIND_SUMMARY;
        a.changed = run_chg;
        a.wsum = s;
        a.ent = entropy_now(s);
        a.mask = mask_now();
        expected_answers = {expected_answers, a};
        named_mask = 0;
        run_chg = 0;
    endtask

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) predict_cell(cur_word);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_words.size() > 0 && pending_words[0].drain) begin
                    s_axis_tvalid <= 1'b0;
                    if (expected_answers.size() == 0 && !(s_axis_tvalid && s_axis_tready))
                        void'(pending_words.pop_front());
                end else if (gap_left > 0) begin
                    s_axis_tvalid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pending_words.size() > 0) begin
                    cur_word = pending_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= cur_word.cmd;
                    s_axis_tlast  <= cur_word.last;
                    s_axis_tdata  <= {3'b0, cur_word.rnd, cur_word.weight, cur_word.pid};
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        cell_answer_t e;
        logic [63:0] d;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                answers_seen++;
                d = {7'd0, 1'b0, m_axis_tdata[56:0]};
                if (expected_answers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word tdata=%h", m_axis_tdata);
                end else begin
                    e = expected_answers.pop_front();
                    if (m_axis_tuser[0] !== e.kind || m_axis_tdata[0] !== e.changed ||
                        m_axis_tdata[20:1] !== e.wsum || m_axis_tdata[34:21] !== e.ent ||
                        m_axis_tdata[50:35] !== e.mask || m_axis_tdata[55:51] !== e.chosen ||
                        m_axis_tdata[56] !== e.contra) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch exp kind=%0d chg=%0d sum=%0d ent=%0d %s",
                                     e.kind, e.changed, e.wsum, e.ent, "");
                            $display("  exp mask=%h pat=%0d con=%0d",
                                     e.mask, e.chosen, e.contra);
                            $display("  got kind=%0d chg=%0d sum=%0d ent=%0d",
                                     m_axis_tuser[0], d[0], d[20:1], d[34:21]);
                            $display("  got mask=%h pat=%0d con=%0d",
                                     d[50:35], d[55:51], d[56]);
                        end
                    end
                end
            end
            if (!long_hold_done && answers_seen == 40) begin
                long_hold_done <= 1;
                stall_hold <= 600;
            end
            if (mode_cnt == 0) begin
                ready_mode <= $urandom_range(0, 2);
                mode_cnt <= $urandom_range(50, 300);
            end else begin
                mode_cnt <= mode_cnt - 1;
            end
            if (stall_hold > 0) begin
                stall_hold <= stall_hold - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= (ready_mode == 0) ? 1'b1 :
                                 (ready_mode == 1) ? ($urandom_range(0, 3) != 0) :
                                                     ($urandom_range(0, 3) == 0);
            end
        end
    end

    task automatic add_word(input logic [1:0] c, input logic [4:0] p, input logic [15:0] w,
                            input logic l, input logic [15:0] r);
        cell_word_t cw;
        cw = '{c, p, w, l, r, 1'b0};
        pending_words = {pending_words, cw};
    endtask

    task automatic add_pause();
        cell_word_t cw;
        cw = '{CMD_NOP, 5'd0, 16'd0, 1'b0, 16'd0, 1'b1};
        pending_words = {pending_words, cw};
    endtask

    function automatic logic [15:0] rand_weight();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 16'd0;
        if (k == 1) return 16'($urandom());
        if (k == 2) return 16'hFFFF;
        return 16'($urandom_range(1, 60));
    endfunction

    function automatic logic [4:0] rand_pid();
        return ($urandom_range(0, 19) == 0) ? 5'($urandom_range(0, 31)) :
                                              5'($urandom_range(1, 16));
    endfunction

    task automatic add_run(input logic [1:0] c, input int n);
        for (int i = 0; i < n; i++)
            add_word(c, rand_pid(), rand_weight(), i == n - 1, 16'($urandom()));
    endtask

    initial begin
        int count, n;
        w_mirror = '{default: '0};
        named_mask = 0;
        run_chg = 0;
        collapsed = 0;
        final_pat = 0;
        // directed
        for (int i = 1; i <= 16; i++) add_word(CMD_LOAD, 5'(i), 16'hFFFF, i == 16, 16'h0);
        add_word(CMD_CONSTRAIN, 5'd3, 16'd0, 1'b0, 16'hFFFF);
        add_word(CMD_CONSTRAIN, 5'd5, 16'd1, 1'b1, 16'h0);
        add_word(CMD_COLLAPSE, 5'd0, 16'd0, 1'b0, 16'h0);
        add_word(CMD_COLLAPSE, 5'd31, 16'hFFFF, 1'b1, 16'hFFFF);
        add_word(CMD_CONSTRAIN, 5'd1, 16'd0, 1'b1, 16'h0);
        add_word(CMD_NOP, 5'd1, 16'd7, 1'b1, 16'h1234);
        add_word(CMD_LOAD, 5'd0, 16'd9, 1'b1, 16'h0);
        add_word(CMD_COLLAPSE, 5'd2, 16'd0, 1'b0, 16'h8000);
        add_word(CMD_LOAD, 5'd16, 16'd1, 1'b0, 16'h0);
        add_word(CMD_COLLAPSE, 5'd0, 16'd0, 1'b0, 16'hFFFF);
        add_word(CMD_LOAD, 5'd17, 16'd5, 1'b0, 16'h0);
        add_word(CMD_CONSTRAIN, 5'd16, 16'd0, 1'b1, 16'h0);
        add_pause();
        count = 0;
        while (count < 1800) begin
            if ($urandom_range(0, 9) == 0) begin
                add_word(2'($urandom_range(0, 3)), 5'($urandom()), 16'($urandom()),
                         1'($urandom()), 16'($urandom()));
                count++;
            end else begin
                n = $urandom_range(1, 16);
                add_run(CMD_LOAD, n);
                count += n;
                repeat ($urandom_range(0, 3)) begin
                    n = $urandom_range(1, 16);
                    add_run(CMD_CONSTRAIN, n);
                    count += n;
                end
                repeat ($urandom_range(0, 2)) begin
                    add_word(CMD_COLLAPSE, 5'($urandom()), 16'($urandom()), 1'($urandom()),
                             16'($urandom()));
                    count++;
                end
            end
            if (count > 900 && count < 930)
                add_pause();
        end
        while (pending_words.size() > 0 || s_axis_tvalid || expected_answers.size() > 0)
            @(posedge aclk);
        repeat (800) @(posedge aclk);
        if (mismatches == 0 && expected_answers.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #60000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
